### src/bpfa_pkg.sv
// Shared types and codes for the bitmap page frame allocator.
// No dependencies; imported by the top level, its checker and the testbench.
`default_nettype none

package bpfa_pkg;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NO_MEM = 2'd1;
    localparam logic [1:0] STAT_RANGE  = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int RAM_MB_W   = 7;
    localparam int RSV_W      = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_RAM_MB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 2'd1;

    localparam logic [RAM_MB_W-1:0] RAM_MB_RESET   = 7'd64;
    localparam logic [RSV_W-1:0]    RESERVED_RESET = 15'd2048;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] free_addr;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page_address;
    } res_item_t;

endpackage

`default_nettype wire

### src/bpfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### src/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator (first fit).
// Depends on bpfa_pkg and bpfa_ram.
`default_nettype none

// One bit per page frame sits in a single RAM of ceil(MAX_PAGES/32) words
// (512 at the defaults); a 1 marks a used page. After reset the block runs
// one write per word to build the map from the reset register values and
// takes no item until done; configuration writes are always taken. Init
// rewrites every word; allocate scans one word per cycle over the one read
// port, from word 0 up until a word holds a free page below the page total
// or the total is passed; free reads the page's word and writes it back
// with the bit cleared. An out-of-range free, an allocate with no pages and
// command 3 go straight to the result. The block handles one item at a
// time; a result sits in an output register and is held there until taken.
module bitmap_page_frame_allocator #(
    parameter int MAX_PAGES  = 16384,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cmd_valid,
    output logic                                       cmd_ready,
    input  wire bpfa_pkg::cmd_item_t                   cmd_item,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output bpfa_pkg::res_item_t                        res_item,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [bpfa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [bpfa_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import bpfa_pkg::*;

    localparam int MAP_WORDS = (MAX_PAGES + 31) / 32;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PGW       = AW + 5;
    localparam int PB_SH     = $clog2(PAGE_BYTES);
    localparam int PPM       = 1048576 / PAGE_BYTES;
    localparam int TOT_W     = $clog2(MAX_PAGES + 1);
    localparam int PROD_W    = RAM_MB_W + $clog2(PPM + 1);
    localparam int CW        = (PROD_W > TOT_W) ? PROD_W : TOT_W;
    localparam int LIM_A     = (TOT_W > RSV_W) ? TOT_W : RSV_W;
    localparam int LIM_W     = ((LIM_A > PGW) ? LIM_A : PGW) + 1;
    localparam int LWW       = LIM_W - 5;
    localparam int RST_PROD  = 64 * PPM;
    localparam int RST_TOTAL = (RST_PROD > MAX_PAGES) ? MAX_PAGES : RST_PROD;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INIT      = 3'd1;
    localparam logic [2:0] S_ALLOC_RD  = 3'd2;
    localparam logic [2:0] S_ALLOC_CHK = 3'd3;
    localparam logic [2:0] S_FREE_RD   = 3'd4;
    localparam logic [2:0] S_FREE_WR   = 3'd5;
    localparam logic [2:0] S_POST      = 3'd6;

    function automatic logic [5:0] word_lim(input logic [LIM_W-1:0] lim,
                                            input logic [AW-1:0] w);
        logic [LWW-1:0] lw;
        logic [LWW-1:0] wx;
        lw = lim[LIM_W-1:5];
        wx = LWW'(w);
        if (lw > wx)
            return 6'd32;
        else if (lw == wx)
            return {1'b0, lim[4:0]};
        else
            return 6'd0;
    endfunction

    function automatic logic [31:0] low_mask(input logic [5:0] n);
        logic [32:0] t;
        t = (33'd1 << n) - 33'd1;
        return t[31:0];
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [RAM_MB_W-1:0] ram_mb_reg;
    logic [RSV_W-1:0]    rsv_reg;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [TOT_W-1:0]    init_total_reg, init_total_next;
    logic [RSV_W-1:0]    init_rsv_reg, init_rsv_next;
    logic                init_item_reg, init_item_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [PGW-1:0]      fpage_reg, fpage_next;
    res_item_t           pend_reg, pend_next;
    logic                res_valid_reg, res_valid_next;
    res_item_t           res_item_reg, res_item_next;

    logic [CW-1:0]       prod;
    logic [TOT_W-1:0]    total_now;
    logic [31:0]         free_page32;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [31:0]         ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [31:0]         ram_rdata;
    logic [31:0]         init_free;
    logic [31:0]         avail;
    logic [31:0]         iso;
    logic [4:0]          bit_idx;
    logic [PGW-1:0]      alloc_page;
    logic [LIM_W-1:0]    next_base;

    assign cfg_ready = 1'b1;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    assign prod        = CW'(ram_mb_reg) * CW'(PPM);
    assign total_now   = (prod > CW'(MAX_PAGES)) ? TOT_W'(MAX_PAGES) : TOT_W'(prod);
    assign free_page32 = cmd_item.free_addr >> PB_SH;

    assign init_free = low_mask(word_lim(LIM_W'(init_total_reg), idx_reg))
                     & ~low_mask(word_lim(LIM_W'(init_rsv_reg), idx_reg));
    assign avail     = ~ram_rdata & low_mask(word_lim(LIM_W'(total_reg), idx_reg));
    assign iso       = avail & (~avail + 32'd1);
    assign alloc_page = {idx_reg, bit_idx};
    assign next_base  = (LIM_W'(idx_reg) + LIM_W'(1)) << 5;

    always_comb
    begin
        bit_idx = 5'd0;
        for (int b = 0; b < 32; b++)
        begin
            if (iso[b])
            begin
                bit_idx = bit_idx | 5'(b);
            end
        end
    end

    bpfa_ram #(
        .WIDTH (32),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        init_total_next = init_total_reg;
        init_rsv_next   = init_rsv_reg;
        init_item_next  = init_item_reg;
        idx_next        = idx_reg;
        fpage_next      = fpage_reg;
        pend_next       = pend_reg;
        res_valid_next  = res_valid_reg;
        res_item_next   = res_item_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ~init_free;
        ram_raddr       = idx_reg;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    total_next = total_now;
                    idx_next   = '0;
                    pend_next  = '{status: STAT_OK, page_address: 32'd0};
                    case (cmd_item.command)
                        CMD_INIT:
                        begin
                            init_total_next = total_now;
                            init_rsv_next   = rsv_reg;
                            init_item_next  = 1'b1;
                            state_next      = S_INIT;
                        end
                        CMD_ALLOC:
                        begin
                            if (total_now == '0)
                            begin
                                pend_next.status = STAT_NO_MEM;
                                state_next       = S_POST;
                            end
                            else
                            begin
                                state_next = S_ALLOC_RD;
                            end
                        end
                        CMD_FREE:
                        begin
                            fpage_next = free_page32[PGW-1:0];
                            if (free_page32 < 32'(total_now))
                            begin
                                state_next = S_FREE_RD;
                            end
                            else
                            begin
                                pend_next.status = STAT_RANGE;
                                state_next       = S_POST;
                            end
                        end
                        default:
                        begin
                            state_next = S_POST;
                        end
                    endcase
                end
            end
            S_INIT:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + AW'(1);
                if (idx_reg == AW'(MAP_WORDS - 1))
                begin
                    idx_next       = '0;
                    init_item_next = 1'b0;
                    state_next     = init_item_reg ? S_POST : S_IDLE;
                end
            end
            S_ALLOC_RD:
            begin
                state_next = S_ALLOC_CHK;
            end
            S_ALLOC_CHK:
            begin
                ram_raddr = idx_reg + AW'(1);
                if (avail != 32'd0)
                begin
                    ram_we                 = 1'b1;
                    ram_wdata              = ram_rdata | iso;
                    pend_next.page_address = 32'(alloc_page) << PB_SH;
                    state_next             = S_POST;
                end
                else if (next_base < LIM_W'(total_reg))
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    pend_next.status = STAT_NO_MEM;
                    state_next       = S_POST;
                end
            end
            S_FREE_RD:
            begin
                ram_raddr  = fpage_reg[PGW-1:5];
                state_next = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fpage_reg[PGW-1:5];
                ram_wdata  = ram_rdata & ~(32'd1 << fpage_reg[4:0]);
                state_next = S_POST;
            end
            S_POST:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = pend_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            ram_mb_reg     <= RAM_MB_RESET;
            rsv_reg        <= RESERVED_RESET;
            init_total_reg <= TOT_W'(RST_TOTAL);
            init_rsv_reg   <= RESERVED_RESET;
            init_item_reg  <= 1'b0;
            idx_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            init_total_reg <= init_total_next;
            init_rsv_reg   <= init_rsv_next;
            init_item_reg  <= init_item_next;
            idx_reg        <= idx_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_valid && cfg_index == CFG_RAM_MB)
            begin
                ram_mb_reg <= cfg_data[RAM_MB_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_RESERVED)
            begin
                rsv_reg <= cfg_data[RSV_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg    <= total_next;
        fpage_reg    <= fpage_next;
        pend_reg     <= pend_next;
        res_item_reg <= res_item_next;
    end

endmodule

`default_nettype wire

### src/bpfa_checker.sv
// Port-level checks for the bitmap page frame allocator, bound to the top level.
// Depends on bpfa_pkg and bitmap_page_frame_allocator.
`default_nettype none

module bpfa_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cmd_valid,
    input wire logic                cmd_ready,
    input wire bpfa_pkg::cmd_item_t cmd_item,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire bpfa_pkg::res_item_t res_item
);

    import bpfa_pkg::*;

    logic cmd_acc;
    assign cmd_acc = cmd_valid && cmd_ready && (cmd_item.command == cmd_item.command);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_item))
        else $error("result item changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_item.status == STAT_OK || res_item.status == STAT_NO_MEM
                       || res_item.status == STAT_RANGE))
        else $error("undefined status code");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.status != STAT_OK |-> res_item.page_address == 32'd0)
        else $error("failed item carries a page address");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |=> !cmd_ready)
        else $error("item taken while previous item still in progress");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
);

`default_nettype wire

### verif/testbench.sv
// Testbench for the bitmap page frame allocator: directed and random commands,
// each result checked against a scoreboard that keeps its own copy of the page bitmap.
// Depends on bpfa_pkg and bitmap_page_frame_allocator.
`timescale 1ns / 1ps

module testbench;
    import bpfa_pkg::*;

    localparam int MAX_PAGES    = 16384;
    localparam int PAGE_BYTES   = 4096;
    localparam int MAP_WORDS    = (MAX_PAGES + 31) / 32;
    localparam int PAGES_PER_MB = 1048576 / PAGE_BYTES;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int IDLE_PCT     = 38;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 95;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 600;

    class frame_ledger;
        bit [31:0]         used_words [MAP_WORDS];
        bit [RAM_MB_W-1:0] ram_mb;
        bit [RSV_W-1:0]    reserved;
        res_item_t         expected_results [$];
        int                mismatches;

        function new();
            ram_mb = RAM_MB_RESET;
            reserved = RESERVED_RESET;
            mismatches = 0;
            rebuild_map();
        endfunction

        function int page_total();
            int n;
            n = int'(ram_mb) * PAGES_PER_MB;
            return (n > MAX_PAGES) ? MAX_PAGES : n;
        endfunction

        function void rebuild_map();
            int total;
            total = page_total();
            foreach (used_words[w])
                used_words[w] = '1;
            for (int p = int'(reserved); p < total; p++)
                used_words[p / 32][p % 32] = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_RAM_MB)
                ram_mb = data[RAM_MB_W-1:0];
            else if (index == CFG_RESERVED)
                reserved = data[RSV_W-1:0];
        endfunction

        function void note_command(cmd_item_t item);
            res_item_t   outcome;
            int          total;
            int          page;
            logic [31:0] frame;
            outcome = '0;
            outcome.status = STAT_OK;
            total = page_total();
            page = -1;
            case (item.command)
                CMD_INIT:
                    rebuild_map();
                CMD_ALLOC:
                begin
                    for (int w = 0; w < MAP_WORDS && page < 0; w++)
                        if (used_words[w] != '1)
                            for (int b = 0; b < 32 && page < 0; b++)
                                if (!used_words[w][b])
                                    page = w * 32 + b;
                    if (page >= 0 && page < total)
                    begin
                        used_words[page / 32][page % 32] = 1'b1;
                        outcome.page_address = page * PAGE_BYTES;
                    end
                    else
                        outcome.status = STAT_NO_MEM;
                end
                CMD_FREE:
                begin
                    frame = item.free_addr / PAGE_BYTES;
                    if (frame < total)
                        used_words[frame / 32][frame % 32] = 1'b0;
                    else
                        outcome.status = STAT_RANGE;
                end
                default:
                    ;
            endcase
            expected_results.push_back(outcome);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_result(res_item_t got);
            res_item_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item: status %0d address %h",
                                          got.status, got.page_address));
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, want.status));
            if (got.page_address !== want.page_address)
                report_mismatch($sformatf("page_address %h, expected %h",
                                          got.page_address, want.page_address));
        endtask
    endclass

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_ready;
    cmd_item_t             cmd_item = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_item_t             res_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_RAM_MB;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit          calm = 1'b0;
    int          quiet_cycles = 0;
    bit [31:0]   held_pages [$];
    frame_ledger ledger;

    bitmap_page_frame_allocator #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            ledger.check_result(res_item);
        res_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int idle_length();
        int n = 0;
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
                n++;
        return n;
    endfunction

    task automatic send_command(logic [1:0] command, logic [31:0] addr);
        cmd_item_t item;
        int        gap;
        item.command = command;
        item.free_addr = addr;
        gap = idle_length();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item <= item;
        do @(posedge clk); while (!cmd_ready);
        ledger.note_command(item);
        if (command == CMD_ALLOC && ledger.expected_results[$].status == STAT_OK)
            held_pages.push_back(ledger.expected_results[$].page_address);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        int gap;
        gap = idle_length();
        if (gap > 0)
        begin
            cfg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        ledger.set_register(index, data);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        while (ledger.expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(logic [RAM_MB_W-1:0] ram, logic [RSV_W-1:0] rsv);
        logic [CFG_DATA_W-1:0] ram_word;
        drain_results();
        ram_word = CFG_DATA_W'($urandom);
        ram_word[RAM_MB_W-1:0] = ram;
        if ($urandom_range(1))
        begin
            write_register(CFG_RAM_MB, ram_word);
            write_register(CFG_RESERVED, rsv);
        end
        else
        begin
            write_register(CFG_RESERVED, rsv);
            write_register(CFG_RAM_MB, ram_word);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [RAM_MB_W-1:0] ram;
        logic [RSV_W-1:0]    rsv;
        int                  total;
        int                  pick;
        int                  slot;
        logic [31:0]         addr;

        ledger = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_ALLOC, 32'hFFFF_FFFF);
        send_command(CMD_FREE, 32'h0080_0ABC);
        send_command(CMD_ALLOC, 32'h1234_5678);
        send_command(CMD_FREE, 32'hFFFF_FFFF);
        send_command(CMD_FREE, 32'h0000_0000);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_FREE, 32'h0400_0000);
        send_command(CMD_FREE, 32'h03FF_FFFF);
        send_command(CMD_SPARE, 32'hA5A5_A5A5);
        send_command(CMD_INIT, 32'h5A5A_5A5A);
        send_command(CMD_ALLOC, 32'h0);

        apply_settings(7'd0, 15'd0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_FREE, 32'h0);
        send_command(CMD_INIT, 32'h0);

        apply_settings(7'd127, 15'd32767);
        send_command(CMD_INIT, 32'h0);
        send_command(CMD_ALLOC, 32'h0);

        apply_settings(7'd127, 15'd16383);
        send_command(CMD_INIT, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_FREE, 32'h03FF_F800);

        apply_settings(7'd1, 15'd16383);
        send_command(CMD_ALLOC, 32'h0);
        send_command(CMD_FREE, 32'h03FF_F000);
        send_command(CMD_FREE, 32'h000F_FFFF);
        send_command(CMD_ALLOC, 32'h0);
        held_pages.delete();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    ram = 7'd127;
                    rsv = 15'd16000;
                end
                1:
                begin
                    ram = 7'd0;
                    rsv = 15'd0;
                end
                2:
                begin
                    ram = 7'd2;
                    rsv = 15'd32767;
                end
                default:
                begin
                    pick = $urandom_range(5);
                    ram = (pick == 0) ? RAM_MB_W'($urandom_range(127)) :
                          (pick == 1) ? 7'd64 : RAM_MB_W'($urandom_range(4, 1));
                    total = int'(ram) * PAGES_PER_MB;
                    if (total > MAX_PAGES)
                        total = MAX_PAGES;
                    pick = $urandom_range(3);
                    if (pick == 0)
                        rsv = RSV_W'($urandom_range(32767));
                    else if (pick == 1 || total < 48)
                        rsv = RSV_W'($urandom_range(total));
                    else
                        rsv = RSV_W'(total - int'($urandom_range(48)));
                end
            endcase
            calm = (phase == 4) || (phase == 9);
            apply_settings(ram, rsv);
            if ($urandom_range(99) < 80)
            begin
                send_command(CMD_INIT, $urandom);
                held_pages.delete();
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                total = ledger.page_total();
                pick = $urandom_range(99);
                if (pick < 45 || (pick < 70 && held_pages.size() == 0))
                    send_command(CMD_ALLOC, $urandom);
                else if (pick < 70)
                begin
                    slot = $urandom_range(held_pages.size() - 1);
                    addr = held_pages[slot] | $urandom_range(PAGE_BYTES - 1);
                    held_pages.delete(slot);
                    send_command(CMD_FREE, addr);
                end
                else if (pick < 76)
                    send_command(CMD_FREE, $urandom);
                else if (pick < 88)
                    send_command(CMD_FREE, $urandom_range((total + 2) * PAGE_BYTES - 1));
                else if (pick < 93)
                begin
                    send_command(CMD_INIT, $urandom);
                    held_pages.delete();
                end
                else
                    send_command(CMD_SPARE, $urandom);
            end
        end

        calm = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
